// ===== hw/rtl/fixed_point_alu_defines.svh =====
// Assertion macros used by the fixed-point ALU back end.
`ifndef FIXED_POINT_ALU_DEFINES_SVH
`define FIXED_POINT_ALU_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define FALU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a sequence that starts with ante; cons may open with a delay.
`define FALU_ASSERT_SEQ(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error(msg);

`endif

// ===== hw/rtl/falu_pkg.sv =====
// Shared types and constants of the fixed-point ALU.
package falu_pkg;

   localparam int DATA_W            = 32;
   localparam int OP_W              = 4;
   localparam int FRAC_BITS_DEFAULT = 8;
   localparam int QUEUE_DEPTH       = 2;

   typedef enum logic [OP_W-1:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_GT       = 4'd4,
      OP_LT       = 4'd5,
      OP_GE       = 4'd6,
      OP_LE       = 4'd7,
      OP_EQ       = 4'd8,
      OP_NE       = 4'd9,
      OP_MIN      = 4'd10,
      OP_MAX      = 4'd11,
      OP_INC      = 4'd12,
      OP_DEC      = 4'd13,
      OP_FROM_INT = 4'd14,
      OP_TO_INT   = 4'd15
   } op_type;

   // Which back-end path produces the value.
   typedef enum logic [1:0] {
      KIND_FAST = 2'd0,
      KIND_MUL  = 2'd1,
      KIND_DIV  = 2'd2
   } kind_type;

   typedef struct packed {
      op_type                    op;
      kind_type                  kind;
      logic signed [DATA_W-1:0]  a;
      logic signed [DATA_W-1:0]  b;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== hw/rtl/falu_front.sv =====
// Front end: accepts command words and classifies them by execution path.
module falu_front (
   input  logic                              start,
   output logic                              busy,
   input  logic [falu_pkg::OP_W-1:0]         req_op,
   input  logic signed [falu_pkg::DATA_W-1:0] req_operand_a,
   input  logic signed [falu_pkg::DATA_W-1:0] req_operand_b,
   input  falu_pkg::q_status_type            q_status,
   output logic                              push,
   output falu_pkg::item_type                push_item
);

   falu_pkg::op_type   op;
   falu_pkg::kind_type kind;

   assign op = falu_pkg::op_type'(req_op);

   always_comb begin
      case (op)
         falu_pkg::OP_MUL: begin
            kind = falu_pkg::KIND_MUL;
         end
         falu_pkg::OP_DIV: begin
            kind = falu_pkg::KIND_DIV;
         end
         default: begin
            kind = falu_pkg::KIND_FAST;
         end
      endcase
   end

   assign busy = q_status.full;
   assign push = start & ~q_status.full;

   assign push_item.op   = op;
   assign push_item.kind = kind;
   assign push_item.a    = req_operand_a;
   assign push_item.b    = req_operand_b;

endmodule

// ===== hw/rtl/falu_queue.sv =====
// Short queue that decouples the front end from the execution back end.
module falu_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  falu_pkg::item_type     push_item,
   input  logic                   pop,
   output falu_pkg::item_type     head,
   output falu_pkg::q_status_type q_status
);

   localparam int PTR_W = (falu_pkg::QUEUE_DEPTH > 1) ? $clog2(falu_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(falu_pkg::QUEUE_DEPTH + 1);

   falu_pkg::item_type slot_ff [falu_pkg::QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(falu_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head           = slot_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == CNT_W'(falu_pkg::QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

endmodule

// ===== hw/rtl/falu_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, signed fix at the end.
module falu_div #(
   parameter int FRAC_BITS = falu_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic signed [falu_pkg::DATA_W-1:0] in_a,
   input  logic signed [falu_pkg::DATA_W-1:0] in_b,
   output logic        [falu_pkg::DATA_W-1:0] out_quotient
);

   localparam int DW    = falu_pkg::DATA_W;
   localparam int QUO_W = DW + FRAC_BITS;

   // Stage i holds the partial remainder and the dividend bits still to use,
   // with quotient bits shifted in at the bottom.
   logic [QUO_W-1:0] dq_ff  [QUO_W+1];
   logic [QUO_W-1:0] dq_in  [QUO_W+1];
   logic [DW-1:0]    rem_ff [QUO_W+1];
   logic [DW-1:0]    rem_in [QUO_W+1];
   logic [DW-1:0]    dvs_ff [QUO_W+1];
   logic [DW-1:0]    dvs_in [QUO_W+1];
   logic             neg_ff [QUO_W+1];
   logic             neg_in [QUO_W+1];
   logic [DW:0]      trial_w [QUO_W];
   logic [DW:0]      diff_w  [QUO_W];
   logic             ge_w    [QUO_W];
   logic [DW-1:0]    a_mag;
   logic [DW-1:0]    quo_ff, quo_in;

   always_comb begin
      a_mag     = in_a[DW-1] ? DW'(-in_a) : DW'(in_a);
      dq_in[0]  = {a_mag, {FRAC_BITS{1'b0}}};
      rem_in[0] = '0;
      dvs_in[0] = in_b[DW-1] ? DW'(-in_b) : DW'(in_b);
      neg_in[0] = in_a[DW-1] ^ in_b[DW-1];
      for (int i = 0; i < QUO_W; i++) begin
         trial_w[i]  = {rem_ff[i], dq_ff[i][QUO_W-1]};
         diff_w[i]   = trial_w[i] - {1'b0, dvs_ff[i]};
         ge_w[i]     = (trial_w[i] >= {1'b0, dvs_ff[i]});
         rem_in[i+1] = ge_w[i] ? diff_w[i][DW-1:0] : trial_w[i][DW-1:0];
         dq_in[i+1]  = {dq_ff[i][QUO_W-2:0], ge_w[i]};
         dvs_in[i+1] = dvs_ff[i];
         neg_in[i+1] = neg_ff[i];
      end
      // Negate the wrapped magnitude to truncate toward zero.
      quo_in = neg_ff[QUO_W] ? (~dq_ff[QUO_W][DW-1:0] + DW'(1)) : dq_ff[QUO_W][DW-1:0];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= QUO_W; i++) begin
         dq_ff[i]  <= dq_in[i];
         rem_ff[i] <= rem_in[i];
         dvs_ff[i] <= dvs_in[i];
         neg_ff[i] <= neg_in[i];
      end
      quo_ff <= quo_in;
   end

   assign out_quotient = quo_ff;

endmodule

// ===== hw/rtl/falu_back.sv =====
// Back end: executes queued words on a fixed-latency pipeline and drives results.
`include "fixed_point_alu_defines.svh"

module falu_back #(
   parameter int FRAC_BITS = falu_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  falu_pkg::item_type                 head,
   input  falu_pkg::q_status_type             q_status,
   output logic                               pop,
   output logic                               rsp_strobe,
   output logic signed [falu_pkg::DATA_W-1:0] rsp_value,
   output logic                               rsp_compare_true,
   output logic                               rsp_divide_by_zero
);

   localparam int DW      = falu_pkg::DATA_W;
   localparam int QUO_W   = DW + FRAC_BITS;
   // Divider: operand register, one stage per quotient bit, sign fix.
   localparam int DIV_LAT = QUO_W + 2;

   typedef struct packed {
      falu_pkg::kind_type  kind;
      logic [DW-1:0]       val;
      logic                cmp;
      logic                dz;
   } lane_type;

   logic signed [DW-1:0]   op_a, op_b;
   lane_type               entry;
   lane_type               lane_ff    [DIV_LAT];
   lane_type               lane_in    [DIV_LAT];
   logic                   lvalid_ff  [DIV_LAT];
   logic                   lvalid_in  [DIV_LAT];
   logic signed [2*DW-1:0] prod_ff, prod_in;
   logic [DW-1:0]          quotient;
   logic                   out_valid_ff, out_valid_in;
   logic [DW-1:0]          out_val_ff, out_val_in;
   logic                   out_cmp_ff, out_cmp_in;
   logic                   out_dz_ff, out_dz_in;

   // The pipeline never stalls, so take the head whenever there is one.
   assign pop  = ~q_status.empty;
   assign op_a = head.a;
   assign op_b = head.b;

   always_comb begin
      entry.kind = head.kind;
      entry.val  = '0;
      entry.cmp  = 1'b0;
      entry.dz   = 1'b0;
      case (head.op)
         falu_pkg::OP_ADD: begin
            entry.val = op_a + op_b;
         end
         falu_pkg::OP_SUB: begin
            entry.val = op_a - op_b;
         end
         falu_pkg::OP_DIV: begin
            entry.dz = (op_b == '0);
         end
         falu_pkg::OP_GT: begin
            entry.cmp = (op_a > op_b);
         end
         falu_pkg::OP_LT: begin
            entry.cmp = (op_a < op_b);
         end
         falu_pkg::OP_GE: begin
            entry.cmp = (op_a >= op_b);
         end
         falu_pkg::OP_LE: begin
            entry.cmp = (op_a <= op_b);
         end
         falu_pkg::OP_EQ: begin
            entry.cmp = (op_a == op_b);
         end
         falu_pkg::OP_NE: begin
            entry.cmp = (op_a != op_b);
         end
         falu_pkg::OP_MIN: begin
            entry.val = (op_a < op_b) ? op_a : op_b;
         end
         falu_pkg::OP_MAX: begin
            entry.val = (op_a > op_b) ? op_a : op_b;
         end
         falu_pkg::OP_INC: begin
            entry.val = op_a + DW'(1);
         end
         falu_pkg::OP_DEC: begin
            entry.val = op_a - DW'(1);
         end
         falu_pkg::OP_FROM_INT: begin
            entry.val = op_a <<< FRAC_BITS;
         end
         falu_pkg::OP_TO_INT: begin
            entry.val = op_a >>> FRAC_BITS;
         end
         default: begin
            entry.val = '0;
         end
      endcase
   end

   assign prod_in = op_a * op_b;

   always_comb begin
      lane_in[0]   = entry;
      lvalid_in[0] = pop;
      // Second stage: pick the scaled product out of the registered multiply.
      lane_in[1]   = lane_ff[0];
      if (lane_ff[0].kind == falu_pkg::KIND_MUL) begin
         lane_in[1].val = prod_ff[FRAC_BITS +: DW];
      end
      lvalid_in[1] = lvalid_ff[0];
      for (int i = 2; i < DIV_LAT; i++) begin
         lane_in[i]   = lane_ff[i-1];
         lvalid_in[i] = lvalid_ff[i-1];
      end
   end

   always_comb begin
      out_valid_in = lvalid_ff[DIV_LAT-1];
      out_cmp_in   = lane_ff[DIV_LAT-1].cmp;
      out_dz_in    = lane_ff[DIV_LAT-1].dz;
      out_val_in   = lane_ff[DIV_LAT-1].val;
      if (lane_ff[DIV_LAT-1].kind == falu_pkg::KIND_DIV) begin
         out_val_in = lane_ff[DIV_LAT-1].dz ? '0 : quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            lvalid_ff[i] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < DIV_LAT; i++) begin
            lvalid_ff[i] <= lvalid_in[i];
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DIV_LAT; i++) begin
         lane_ff[i] <= lane_in[i];
      end
      prod_ff    <= prod_in;
      out_val_ff <= out_val_in;
      out_cmp_ff <= out_cmp_in;
      out_dz_ff  <= out_dz_in;
   end

   falu_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock        (clock),
      .in_a         (op_a),
      .in_b         (op_b),
      .out_quotient (quotient)
   );

   assign rsp_strobe         = out_valid_ff;
   assign rsp_value          = out_val_ff;
   assign rsp_compare_true   = out_cmp_ff;
   assign rsp_divide_by_zero = out_dz_ff;

   `FALU_ASSERT_SEQ(a_pop_to_result, clock, reset, pop, ##(DIV_LAT + 1) out_valid_ff, "popped word did not reach the output on time")
   `FALU_ASSERT_IMPL(a_dz_clean, clock, reset, out_valid_ff && out_dz_ff, out_val_ff == '0 && !out_cmp_ff, "divide by zero result not cleared")
   `FALU_ASSERT_IMPL(a_cmp_zero_value, clock, reset, out_valid_ff && out_cmp_ff, out_val_ff == '0 && !out_dz_ff, "comparison result carries a value")

endmodule

// ===== hw/rtl/fixed_point_alu.sv =====
// Top level of the signed fixed-point ALU (raw words with FRAC_BITS fraction bits).
//
// Command channel: drive req_op, req_operand_a and req_operand_b with start high;
// the word is taken at the rising edge where start is high and busy is low.
// Result channel: rsp_strobe is high for exactly one cycle with rsp_value,
// rsp_compare_true and rsp_divide_by_zero; the receiver cannot hold it off.
// Results come out in command order, one per command.
// Every opcode takes a path of the same length from the accepting edge to the
// strobe. The restoring divider, one quotient bit per stage over 32 + FRAC_BITS
// stages, sets this length; other opcodes ride a delay line of the same length.
// Throughput: one command per cycle. The execution pipeline drains the
// two-entry queue every cycle, so busy stays low in normal operation.
// Reset (synchronous, active high) empties the queue and drops every word
// in flight; no strobe follows for commands taken before reset.
// Divide by zero returns value 0 with rsp_divide_by_zero set; all other
// overflow wraps to 32 bits silently.
module fixed_point_alu #(
   parameter int FRAC_BITS = falu_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic        [falu_pkg::OP_W-1:0]   req_op,
   input  logic signed [falu_pkg::DATA_W-1:0] req_operand_a,
   input  logic signed [falu_pkg::DATA_W-1:0] req_operand_b,
   output logic                               rsp_strobe,
   output logic signed [falu_pkg::DATA_W-1:0] rsp_value,
   output logic                               rsp_compare_true,
   output logic                               rsp_divide_by_zero
);

   falu_pkg::q_status_type q_status;
   falu_pkg::item_type     push_item;
   falu_pkg::item_type     head;
   logic                   push;
   logic                   pop;

   falu_front u_front (
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .q_status      (q_status),
      .push          (push),
      .push_item     (push_item)
   );

   falu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .q_status  (q_status)
   );

   falu_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .q_status           (q_status),
      .pop                (pop),
      .rsp_strobe         (rsp_strobe),
      .rsp_value          (rsp_value),
      .rsp_compare_true   (rsp_compare_true),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

endmodule

// ===== test/fixed_point_alu_tb.sv =====
// Self-checking testbench for the fixed-point ALU: random and corner commands against a predictor.
`timescale 1ns / 100ps

module fixed_point_alu_tb;

   localparam int FRAC         = falu_pkg::FRAC_BITS_DEFAULT;
   localparam int DW           = falu_pkg::DATA_W;
   localparam int PIPE_LATENCY = 35 + FRAC;
   localparam int RANDOM_CMDS  = 1150;
   localparam logic signed [DW-1:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DW-1:0] WORD_MIN = 32'sh8000_0000;

   typedef struct {
      falu_pkg::op_type     op;
      logic signed [DW-1:0] a;
      logic signed [DW-1:0] b;
      bit                   drain_first;
   } alu_cmd_type;

   typedef struct {
      falu_pkg::op_type     op;
      logic signed [DW-1:0] a;
      logic signed [DW-1:0] b;
      logic signed [DW-1:0] value;
      logic                 compare_true;
      logic                 divide_by_zero;
   } alu_outcome_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [falu_pkg::OP_W-1:0]     req_op = '0;
   logic signed [DW-1:0]          req_operand_a = '0;
   logic signed [DW-1:0]          req_operand_b = '0;
   logic                          rsp_strobe;
   logic signed [DW-1:0]          rsp_value;
   logic                          rsp_compare_true;
   logic                          rsp_divide_by_zero;

   alu_cmd_type     cmd_backlog[$];
   alu_outcome_type outcomes_owed[$];
   int              results_owed = 0;
   int              words_sent = 0;
   int              words_checked = 0;
   int              mismatches = 0;
   int              div_zero_seen = 0;
   int              compare_hits = 0;
   int              op_hits[16];

   fixed_point_alu dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_operand_a      (req_operand_a),
      .req_operand_b      (req_operand_b),
      .rsp_strobe         (rsp_strobe),
      .rsp_value          (rsp_value),
      .rsp_compare_true   (rsp_compare_true),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   // Compute one ALU result; products and scaled dividends are taken at 64 bits.
   function automatic alu_outcome_type fixed_alu_eval(input falu_pkg::op_type op,
         input logic signed [DW-1:0] a, input logic signed [DW-1:0] b);
      alu_outcome_type r;
      longint          wide;
      r.op = op;
      r.a = a;
      r.b = b;
      r.value = '0;
      r.compare_true = 1'b0;
      r.divide_by_zero = 1'b0;
      case (op)
         falu_pkg::OP_ADD: r.value = a + b;
         falu_pkg::OP_SUB: r.value = a - b;
         falu_pkg::OP_MUL: begin
            wide = longint'(a) * longint'(b);
            wide = wide >>> FRAC;
            r.value = wide[DW-1:0];
         end
         falu_pkg::OP_DIV: begin
            if (b == 0) begin
               r.divide_by_zero = 1'b1;
            end else begin
               wide = (longint'(a) <<< FRAC) / longint'(b);
               r.value = wide[DW-1:0];
            end
         end
         falu_pkg::OP_GT:       r.compare_true = (a > b);
         falu_pkg::OP_LT:       r.compare_true = (a < b);
         falu_pkg::OP_GE:       r.compare_true = (a >= b);
         falu_pkg::OP_LE:       r.compare_true = (a <= b);
         falu_pkg::OP_EQ:       r.compare_true = (a == b);
         falu_pkg::OP_NE:       r.compare_true = (a != b);
         falu_pkg::OP_MIN:      r.value = (a < b) ? a : b;
         falu_pkg::OP_MAX:      r.value = (a > b) ? a : b;
         falu_pkg::OP_INC:      r.value = a + 32'sd1;
         falu_pkg::OP_DEC:      r.value = a - 32'sd1;
         falu_pkg::OP_FROM_INT: r.value = a <<< FRAC;
         default:               r.value = a >>> FRAC;
      endcase
      return r;
   endfunction

   function automatic void queue_cmd(input falu_pkg::op_type op,
         input logic signed [DW-1:0] a, input logic signed [DW-1:0] b,
         input bit drain_first);
      alu_cmd_type c;
      c.op = op;
      c.a = a;
      c.b = b;
      c.drain_first = drain_first;
      cmd_backlog.push_back(c);
   endfunction

   function automatic logic signed [DW-1:0] pick_operand();
      case ($urandom_range(9))
         0:       return WORD_MAX;
         1:       return WORD_MIN;
         2:       return $signed($urandom_range(2)) - 32'sd1;
         3, 4:    return $signed($urandom_range(8191)) - 32'sd4096;
         5:       return $signed($urandom_range(65535)) <<< FRAC;
         default: return $urandom();
      endcase
   endfunction

   function automatic bit is_compare(input falu_pkg::op_type op);
      return op inside {falu_pkg::OP_GT, falu_pkg::OP_LT, falu_pkg::OP_GE,
                        falu_pkg::OP_LE, falu_pkg::OP_EQ, falu_pkg::OP_NE};
   endfunction

   // Driver: hold a word until taken, then advance to the next one or idle.
   always @(posedge clock) begin
      logic took;
      logic go;
      int   in_flight;
      took = start && !busy;
      go = 1'b0;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (took) begin
            void'(cmd_backlog.pop_front());
            words_sent++;
         end
         go = start && !took;
         if (!go && cmd_backlog.size() != 0) begin
            in_flight = results_owed + (took ? 1 : 0);
            if (cmd_backlog[0].drain_first && in_flight != 0)
               go = 1'b0;
            else if (!(words_sent >= 400 && words_sent < 700) && $urandom_range(99) < 10)
               go = 1'b0;
            else begin
               go = 1'b1;
               req_op <= cmd_backlog[0].op;
               req_operand_a <= cmd_backlog[0].a;
               req_operand_b <= cmd_backlog[0].b;
            end
         end
         start <= go;
      end
   end

   // Monitor: check the result first, then log the word taken at this edge.
   always @(posedge clock) begin
      alu_outcome_type due;
      if (!reset) begin
         if (rsp_strobe !== 1'b0) begin
            if (outcomes_owed.size() == 0) begin
               report_mismatch($sformatf("unexpected result value=%0d strobe=%b",
                  rsp_value, rsp_strobe));
            end else begin
               due = outcomes_owed.pop_front();
               words_checked++;
               if (rsp_value !== due.value)
                  report_mismatch($sformatf("%s a=%0d b=%0d: value %0d, want %0d",
                     due.op.name(), due.a, due.b, rsp_value, due.value));
               if (rsp_compare_true !== due.compare_true)
                  report_mismatch($sformatf("%s a=%0d b=%0d: compare_true %b, want %b",
                     due.op.name(), due.a, due.b, rsp_compare_true, due.compare_true));
               if (rsp_divide_by_zero !== due.divide_by_zero)
                  report_mismatch($sformatf("%s a=%0d b=%0d: divide_by_zero %b, want %b",
                     due.op.name(), due.a, due.b, rsp_divide_by_zero,
                     due.divide_by_zero));
            end
         end
         if (start && !busy) begin
            due = fixed_alu_eval(falu_pkg::op_type'(req_op), req_operand_a, req_operand_b);
            outcomes_owed.push_back(due);
            op_hits[req_op]++;
            if (due.divide_by_zero)
               div_zero_seen++;
            if (due.compare_true)
               compare_hits++;
         end
      end
      results_owed <= outcomes_owed.size();
   end

   initial begin
      falu_pkg::op_type     o;
      falu_pkg::op_type     rop;
      logic signed [DW-1:0] ra;
      logic signed [DW-1:0] rb;
      int                   ops_covered;

      // Every opcode at the range extremes.
      o = o.first();
      do begin
         queue_cmd(o, WORD_MAX, WORD_MIN, 1'b0);
         o = o.next();
      end while (o != o.first());
      queue_cmd(falu_pkg::OP_DIV, 32'sd5, 32'sd0, 1'b0);
      queue_cmd(falu_pkg::OP_DIV, 32'sd0, 32'sd0, 1'b0);
      queue_cmd(falu_pkg::OP_DIV, WORD_MIN, -32'sd1, 1'b0);
      queue_cmd(falu_pkg::OP_MUL, WORD_MAX, WORD_MAX, 1'b0);
      queue_cmd(falu_pkg::OP_MUL, WORD_MIN, WORD_MIN, 1'b0);
      queue_cmd(falu_pkg::OP_EQ, WORD_MIN, WORD_MIN, 1'b0);
      queue_cmd(falu_pkg::OP_ADD, WORD_MAX, 32'sd1, 1'b0);
      queue_cmd(falu_pkg::OP_INC, WORD_MAX, 32'sd0, 1'b0);
      queue_cmd(falu_pkg::OP_DEC, WORD_MIN, -32'sd1, 1'b0);

      for (int i = 0; i < RANDOM_CMDS; i++) begin
         rop = falu_pkg::op_type'($urandom_range(15));
         ra = pick_operand();
         rb = pick_operand();
         if (rop == falu_pkg::OP_DIV && $urandom_range(5) == 0)
            rb = '0;
         if (is_compare(rop) && $urandom_range(3) == 0)
            rb = ra;
         queue_cmd(rop, ra, rb, (i == 300 || i == 850));
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (cmd_backlog.size() != 0 || start)
         @(negedge clock);
      while (results_owed != 0)
         @(negedge clock);
      repeat (2 * PIPE_LATENCY) @(negedge clock);

      if (outcomes_owed.size() != 0)
         report_mismatch($sformatf("%0d results never came out", outcomes_owed.size()));

      ops_covered = 0;
      foreach (op_hits[k])
         if (op_hits[k] != 0)
            ops_covered++;
      $display("Run covered %0d commands (%0d results checked) over %0d of 16 opcodes.",
         words_sent, words_checked, ops_covered);
      $display("Divides by zero: %0d, true comparisons: %0d, mismatches: %0d.",
         div_zero_seen, compare_hits, mismatches);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #400000;
      $display("watchdog expired with %0d results outstanding", outcomes_owed.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
